// ===== hw/rtl/cfhtm_pkg.sv =====
// Shared types, constants and hash helpers for the case-folded hash target matcher.
`default_nettype none

package cfhtm_pkg;

  // Target table geometry.
  localparam int MAX_TARGETS = 64;
  localparam int IDX_W       = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W       = $clog2(MAX_TARGETS + 1);

  // Command queue between the front and back ends.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Field widths of the stream payloads.
  localparam int HASH_W   = 32;
  localparam int MCOUNT_W = 7;
  localparam int FIRST_W  = 6;
  localparam int TOTAL_W  = 16;

  // Input transaction modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_CHAR  = 2'd2;

  // Character constants.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Commands handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_WORD  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [HASH_W-1:0]   value;  // target hash for a load, final hash for a word
  } cmd_t;

  // Fold uppercase to lowercase and sign-extend high bytes.
  function automatic logic [HASH_W-1:0] fold_char(input logic [7:0] b);
    logic [HASH_W-1:0] c;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      c = {{(HASH_W-8){1'b0}}, b + CASE_OFFSET};
    end else begin
      c = {{(HASH_W-8){b[7]}}, b};
    end
    return c;
  endfunction

  // One sdbm step: h * 65599 + c, written as shifts and adds.
  function automatic logic [HASH_W-1:0] sdbm_step(input logic [HASH_W-1:0] h,
                                                  input logic [HASH_W-1:0] c);
    return (h << 16) + (h << 6) - h + c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfhtm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module cfhtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr,
  input  wire logic [WIDTH-1:0]                  wdata,
  input  wire logic                              re,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr,
  output logic      [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfhtm_front.sv =====
// Front end: accepts input transactions, keeps the running word hash, issues commands.
`default_nettype none

module cfhtm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        mode,
  input  wire logic [7:0]        char_byte,
  input  wire logic              word_end,
  input  wire logic [31:0]       target_value,
  output logic                   push,
  output cfhtm_pkg::cmd_t        push_cmd,
  input  wire logic              q_full
);

  logic                          accept;
  logic [cfhtm_pkg::HASH_W-1:0]  hash_accum;
  logic [cfhtm_pkg::HASH_W-1:0]  hash_accum_next;
  logic [cfhtm_pkg::HASH_W-1:0]  hash_upd;
  logic                          skip_lf;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A line feed on the last character of a word is stripped rather than hashed.
  assign skip_lf  = word_end && (char_byte == cfhtm_pkg::CHAR_LF);
  assign hash_upd = skip_lf ? hash_accum
                            : cfhtm_pkg::sdbm_step(hash_accum, cfhtm_pkg::fold_char(char_byte));

  // Classify the transaction into a command and the next hash value.
  always_comb begin
    push            = 1'b0;
    push_cmd.kind   = cfhtm_pkg::CMD_CLEAR;
    push_cmd.value  = target_value;
    hash_accum_next = hash_accum;
    if (accept) begin
      unique case (mode)
        cfhtm_pkg::MODE_CLEAR: begin
          push            = 1'b1;
          push_cmd.kind   = cfhtm_pkg::CMD_CLEAR;
          hash_accum_next = '0;
        end
        cfhtm_pkg::MODE_LOAD: begin
          push          = 1'b1;
          push_cmd.kind = cfhtm_pkg::CMD_LOAD;
        end
        cfhtm_pkg::MODE_CHAR: begin
          if (word_end) begin
            push            = 1'b1;
            push_cmd.kind   = cfhtm_pkg::CMD_WORD;
            push_cmd.value  = hash_upd;
            hash_accum_next = '0;
          end else begin
            hash_accum_next = hash_upd;
          end
        end
        default: begin
          hash_accum_next = hash_accum;
        end
      endcase
    end
  end

  // Running hash register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_accum <= '0;
    end else begin
      hash_accum <= hash_accum_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfhtm_fifo.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module cfhtm_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cfhtm_pkg::cmd_t  push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output cfhtm_pkg::cmd_t       head_cmd,
  output logic                  not_empty
);

  cfhtm_pkg::cmd_t                 slots [cfhtm_pkg::QDEPTH];
  logic [cfhtm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [cfhtm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [cfhtm_pkg::QCNT_W-1:0]    fill;

  assign full      = (fill == cfhtm_pkg::QCNT_W'(cfhtm_pkg::QDEPTH));
  assign not_empty = (fill != '0);
  assign head_cmd  = slots[rd_ptr];

  // Pointer advance with wrap at the queue depth.
  function automatic logic [cfhtm_pkg::QPTR_W-1:0] bump(input logic [cfhtm_pkg::QPTR_W-1:0] p);
    return (p == cfhtm_pkg::QPTR_W'(cfhtm_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfhtm_back.sv =====
// Back end: owns the target table, scans it for each word and drives the result register.
`default_nettype none

module cfhtm_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire cfhtm_pkg::cmd_t                   q_cmd,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cfhtm_pkg::HASH_W-1:0]           out_hash,
  output logic [cfhtm_pkg::MCOUNT_W-1:0]         out_mcount,
  output logic [cfhtm_pkg::FIRST_W-1:0]          out_first,
  output logic                                   out_any,
  output logic [cfhtm_pkg::TOTAL_W-1:0]          out_total,
  output logic                                   out_all,
  output logic                                   out_coll
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                          state, state_next;
  logic [cfhtm_pkg::CNT_W-1:0]     tcount, tcount_next;
  logic [cfhtm_pkg::TOTAL_W-1:0]   total, total_next;
  logic [cfhtm_pkg::HASH_W-1:0]    hash, hash_next;
  logic [cfhtm_pkg::CNT_W-1:0]     issue_cnt, issue_cnt_next;
  logic [cfhtm_pkg::IDX_W-1:0]     cmp_idx, cmp_idx_next;
  logic [cfhtm_pkg::CNT_W-1:0]     mcnt, mcnt_next;
  logic [cfhtm_pkg::IDX_W-1:0]     first, first_next;

  logic                            ram_we;
  logic                            ram_re;
  logic [cfhtm_pkg::IDX_W-1:0]     ram_raddr;
  logic [cfhtm_pkg::HASH_W-1:0]    ram_rdata;
  logic                            hit;
  logic                            last;
  logic                            has_room;
  logic                            out_load;
  logic [cfhtm_pkg::TOTAL_W:0]     total_sum;
  logic [cfhtm_pkg::TOTAL_W-1:0]   total_sat;

  assign has_room = (tcount < cfhtm_pkg::CNT_W'(cfhtm_pkg::MAX_TARGETS));
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign ram_we   = q_pop && (q_cmd.kind == cfhtm_pkg::CMD_LOAD) && has_room;

  // Reads run one entry ahead of the compare.
  assign ram_re    = (q_pop && (q_cmd.kind == cfhtm_pkg::CMD_WORD))
                  || ((state == S_SCAN) && (issue_cnt < tcount));
  assign ram_raddr = (state == S_IDLE) ? '0 : issue_cnt[cfhtm_pkg::IDX_W-1:0];

  cfhtm_ram #(
    .WIDTH (cfhtm_pkg::HASH_W),
    .DEPTH (cfhtm_pkg::MAX_TARGETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tcount[cfhtm_pkg::IDX_W-1:0]),
    .wdata (q_cmd.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit  = (ram_rdata == hash);
  assign last = (cfhtm_pkg::CNT_W'(cmp_idx) == (tcount - 1'b1));

  // Saturating running total for the word being finished.
  assign total_sum = {1'b0, total} + (cfhtm_pkg::TOTAL_W + 1)'(mcnt);
  assign total_sat = total_sum[cfhtm_pkg::TOTAL_W] ? '1 : total_sum[cfhtm_pkg::TOTAL_W-1:0];
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  // Command sequencing and table scan.
  always_comb begin
    state_next     = state;
    tcount_next    = tcount;
    total_next     = total;
    hash_next      = hash;
    issue_cnt_next = issue_cnt;
    cmp_idx_next   = cmp_idx;
    mcnt_next      = mcnt;
    first_next     = first;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            cfhtm_pkg::CMD_CLEAR: begin
              tcount_next = '0;
              total_next  = '0;
            end
            cfhtm_pkg::CMD_LOAD: begin
              if (has_room) begin
                tcount_next = tcount + 1'b1;
              end
            end
            cfhtm_pkg::CMD_WORD: begin
              hash_next      = q_cmd.value;
              issue_cnt_next = cfhtm_pkg::CNT_W'(1);
              cmp_idx_next   = '0;
              mcnt_next      = '0;
              first_next     = '0;
              state_next     = (tcount == '0) ? S_FIN : S_SCAN;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          mcnt_next = mcnt + 1'b1;
          if (mcnt == '0) begin
            first_next = cmp_idx;
          end
        end
        if (issue_cnt < tcount) begin
          issue_cnt_next = issue_cnt + 1'b1;
        end
        cmp_idx_next = cmp_idx + 1'b1;
        if (last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          total_next = total_sat;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      tcount <= '0;
      total  <= '0;
    end else begin
      state  <= state_next;
      tcount <= tcount_next;
      total  <= total_next;
    end
  end

  // Scan working registers.
  always_ff @(posedge clk) begin
    hash      <= hash_next;
    issue_cnt <= issue_cnt_next;
    cmp_idx   <= cmp_idx_next;
    mcnt      <= mcnt_next;
    first     <= first_next;
  end

  // Result register: holds a finished result while the next word is scanned.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hash   <= hash;
      out_mcount <= cfhtm_pkg::MCOUNT_W'(mcnt);
      out_first  <= cfhtm_pkg::FIRST_W'(first);
      out_any    <= (mcnt != '0);
      out_total  <= total_sat;
      out_all    <= (total_sat == cfhtm_pkg::TOTAL_W'(tcount));
      out_coll   <= (total_sat > cfhtm_pkg::TOTAL_W'(tcount));
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/case_folded_hash_target_match_unit.sv =====
// Top level of the case-folded sdbm hash matcher: front end, command queue, back end.
// Throughput: one input transaction per cycle while the command queue has room.
// The back end takes a clear or load in its idle state; a word runs a table scan
// that reads one RAM entry per cycle.
// Synchronous active-high reset empties the queue, zeroes the hash, count and total.
`default_nettype none

module case_folded_hash_target_match_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // char_byte[7:0], target_value[39:8]
  input  wire logic        s_axis_tlast,   // word_end
  input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // word_hash[31:0], match_count[38:32],
                                           // first_match_res[44:39], any_match[45],
                                           // total_found[61:46], all_found[62],
                                           // collision[63]
);

  logic             push;
  cfhtm_pkg::cmd_t  push_cmd;
  logic             q_full;
  logic             q_pop;
  cfhtm_pkg::cmd_t  q_cmd;
  logic             q_valid;

  logic [cfhtm_pkg::HASH_W-1:0]    word_hash;
  logic [cfhtm_pkg::MCOUNT_W-1:0]  match_count;
  logic [cfhtm_pkg::FIRST_W-1:0]   first_match_res;
  logic                            any_match;
  logic [cfhtm_pkg::TOTAL_W-1:0]   total_found;
  logic                            all_found;
  logic                            collision;

  // Front end: classify and hash.
  cfhtm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .mode         (s_axis_tuser),
    .char_byte    (s_axis_tdata[7:0]),
    .word_end     (s_axis_tlast),
    .target_value (s_axis_tdata[39:8]),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  // Command queue.
  cfhtm_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_cmd  (q_cmd),
    .not_empty (q_valid)
  );

  // Back end: table and matching.
  cfhtm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_hash   (word_hash),
    .out_mcount (match_count),
    .out_first  (first_match_res),
    .out_any    (any_match),
    .out_total  (total_found),
    .out_all    (all_found),
    .out_coll   (collision)
  );

  // Pack the result fields, highest field first.
  assign m_axis_tdata = {collision, all_found, total_found, any_match,
                         first_match_res, match_count, word_hash};

endmodule

`default_nettype wire

// ===== hw/rtl/cfhtm_checker.sv =====
// Port-level checker for the hash matcher, bound to the top level.
`default_nettype none

module cfhtm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result transaction holds its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The match flag agrees with the match count.
  a_any_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[45] == (m_axis_tdata[38:32] != 7'd0)))
    else $error("any_match disagrees with match_count");

  // All-found and collision exclude each other, and a nonzero first index needs a match.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[62] && m_axis_tdata[63])
                      && ((m_axis_tdata[44:39] == 6'd0) || m_axis_tdata[45]))
    else $error("inconsistent result flags");

endmodule

bind case_folded_hash_target_match_unit cfhtm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
